[src/swmf_pkg.sv]
// ----------------------------------------------------------------------------
// swmf_pkg: shared types and constants of the window mean flux block
// widths, register indexes, queue entry and status bundles
// ----------------------------------------------------------------------------
package swmf_pkg;

   // field widths
   localparam int FLUX_BITS = 32;
   localparam int WAVE_BITS = 18;
   localparam int SUM_BITS  = 64;

   // derived widths
   localparam int SPAN_BITS = WAVE_BITS + 1;
   localparam int W2_BITS   = WAVE_BITS + 2;
   localparam int DIV_BITS  = SPAN_BITS + 2;
   localparam int PROD_BITS = FLUX_BITS + W2_BITS;
   localparam int WIDE_BITS = (PROD_BITS > SUM_BITS) ? PROD_BITS : SUM_BITS;
   localparam int CNT_BITS  = $clog2(SUM_BITS);

   // term queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   // register port
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam logic REG_WINDOW_START = 1'b0;
   localparam logic REG_WINDOW_END   = 1'b1;

   localparam logic [WAVE_BITS-1:0] WINDOW_START_RESET = WAVE_BITS'(72000);
   localparam logic [WAVE_BITS-1:0] WINDOW_END_RESET   = WAVE_BITS'(136000);

   typedef logic        [WAVE_BITS-1:0] wave_type;
   typedef logic signed [FLUX_BITS-1:0] flux_type;
   typedef logic signed [SUM_BITS-1:0]  sum_type;
   typedef logic signed [SPAN_BITS-1:0] span_type;
   typedef logic signed [W2_BITS-1:0]   w2_type;

   // one unit of work for the back end
   typedef struct packed {
      flux_type target;
      flux_type model;
      w2_type   w2;
      logic     acc;
      logic     finish;
      span_type span;
      logic     empty;
   } term_type;

   typedef struct packed {
      logic full;
      logic nonempty;
   } queue_status_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[src/swmf_front.sv]
// ----------------------------------------------------------------------------
// swmf_front: sample intake and window classification
// holds one sample back, forms its doubled bin width, tracks the window run
// and the span, and queues accumulate and finish terms for the back end
// ----------------------------------------------------------------------------
module swmf_front (
   input  logic                       clock,
   input  logic                       reset,
   input  swmf_pkg::wave_type         window_start,
   input  swmf_pkg::wave_type         window_end,
   input  logic                       push,
   output logic                       full,
   input  swmf_pkg::wave_type         wavelength,
   input  swmf_pkg::flux_type         target_flux,
   input  swmf_pkg::flux_type         model_flux,
   input  logic                       last_sample,
   input  swmf_pkg::queue_status_type q_status,
   output logic                       q_push,
   output swmf_pkg::term_type         q_data
);
   import swmf_pkg::*;

   wave_type before_ff, before_in;
   wave_type held_wl_ff, held_wl_in;
   flux_type held_t_ff, held_t_in;
   flux_type held_m_ff, held_m_in;
   logic     held_valid_ff, held_valid_in;
   logic     held_first_ff, held_first_in;
   logic     opened_ff, opened_in;
   logic     closed_ff, closed_in;
   wave_type first_ff, first_in;
   wave_type last_ff, last_in;
   logic     pending_ff, pending_in;

   logic     accept;
   logic     step;
   logic     finish;
   logic     take_reach;
   logic     take_close;
   logic     take_acc;
   span_type diff_held;
   span_type diff_new;
   span_type diff_before;
   w2_type   w2;
   logic     next_opened;
   wave_type next_first;
   wave_type next_last;
   span_type span;

   // handshake and step control
   always_comb begin
      full   = q_status.full || pending_ff;
      accept = push && !full;
      finish = pending_ff && !q_status.full;
      step   = (accept && held_valid_ff) || finish;
   end

   // window decision for the held sample
   always_comb begin
      take_reach = !closed_ff && (opened_ff || (held_wl_ff >= window_start));
      take_close = take_reach && (held_wl_ff >= window_end);
      take_acc   = take_reach && !(held_wl_ff >= window_end);
   end

   // doubled bin width of the held sample
   always_comb begin
      diff_new    = span_type'({1'b0, wavelength}) - span_type'({1'b0, held_wl_ff});
      diff_before = span_type'({1'b0, wavelength}) - span_type'({1'b0, before_ff});
      diff_held   = span_type'({1'b0, held_wl_ff}) - span_type'({1'b0, before_ff});
      if (pending_ff) begin
         w2 = held_first_ff ? '0 : w2_type'({diff_held, 1'b0});
      end else begin
         w2 = held_first_ff ? w2_type'({diff_new, 1'b0}) : w2_type'(diff_before);
      end
   end

   // span after this take
   always_comb begin
      next_opened = opened_ff || take_acc;
      next_first  = (take_acc && !opened_ff) ? held_wl_ff : first_ff;
      next_last   = take_acc ? held_wl_ff : last_ff;
      span        = span_type'({1'b0, next_last}) - span_type'({1'b0, next_first});
   end

   // queue entry
   always_comb begin
      q_push        = step && (finish || take_acc);
      q_data.target = held_t_ff;
      q_data.model  = held_m_ff;
      q_data.w2     = w2;
      q_data.acc    = take_acc;
      q_data.finish = finish;
      q_data.span   = span;
      q_data.empty  = !next_opened || (span == '0);
   end

   // spectrum state update
   always_comb begin
      before_in     = before_ff;
      held_wl_in    = held_wl_ff;
      held_t_in     = held_t_ff;
      held_m_in     = held_m_ff;
      held_valid_in = held_valid_ff;
      held_first_in = held_first_ff;
      opened_in     = opened_ff;
      closed_in     = closed_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      pending_in    = pending_ff;
      if (step) begin
         if (take_close) begin
            closed_in = 1'b1;
         end
         opened_in = next_opened;
         first_in  = next_first;
         last_in   = next_last;
      end
      if (accept) begin
         if (held_valid_ff) begin
            before_in     = held_wl_ff;
            held_first_in = 1'b0;
         end
         held_wl_in    = wavelength;
         held_t_in     = target_flux;
         held_m_in     = model_flux;
         held_valid_in = 1'b1;
         pending_in    = last_sample;
      end
      // end of spectrum: start over
      if (finish) begin
         before_in     = '0;
         held_wl_in    = '0;
         held_valid_in = 1'b0;
         held_first_in = 1'b1;
         opened_in     = 1'b0;
         closed_in     = 1'b0;
         first_in      = '0;
         last_in       = '0;
         pending_in    = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         before_ff     <= '0;
         held_wl_ff    <= '0;
         held_valid_ff <= 1'b0;
         held_first_ff <= 1'b1;
         opened_ff     <= 1'b0;
         closed_ff     <= 1'b0;
         first_ff      <= '0;
         last_ff       <= '0;
         pending_ff    <= 1'b0;
      end else begin
         before_ff     <= before_in;
         held_wl_ff    <= held_wl_in;
         held_valid_ff <= held_valid_in;
         held_first_ff <= held_first_in;
         opened_ff     <= opened_in;
         closed_ff     <= closed_in;
         first_ff      <= first_in;
         last_ff       <= last_in;
         pending_ff    <= pending_in;
      end
   end

   // held flux payload
   always_ff @(posedge clock) begin
      held_t_ff <= held_t_in;
      held_m_ff <= held_m_in;
   end

endmodule

[src/swmf_queue.sv]
// ----------------------------------------------------------------------------
// swmf_queue: short term queue between front and back end
// first-in first-out store of four entries with occupancy count
// ----------------------------------------------------------------------------
module swmf_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  swmf_pkg::term_type         wr_data,
   input  logic                       pop,
   output swmf_pkg::term_type         rd_data,
   output swmf_pkg::queue_status_type status
);
   import swmf_pkg::*;

   term_type               mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data         = mem_ff[rd_ptr_ff];
   assign status.full     = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign status.nonempty = (count_ff != '0);

endmodule

[src/swmf_divider.sv]
// ----------------------------------------------------------------------------
// swmf_divider: shared restoring divider for both window sums
// one quotient bit per cycle, magnitude division by four times the span,
// signed and saturated to the flux range at the end
// ----------------------------------------------------------------------------
module swmf_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  swmf_pkg::sum_type        dividend_a,
   input  swmf_pkg::sum_type        dividend_b,
   input  swmf_pkg::span_type       span,
   output swmf_pkg::div_status_type status,
   output swmf_pkg::flux_type       level_a,
   output swmf_pkg::flux_type       level_b
);
   import swmf_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [SUM_BITS-1:0] dvd_a_ff, dvd_b_ff;
   logic [DIV_BITS-1:0] rem_a_ff, rem_b_ff;
   logic [DIV_BITS-1:0] dvsr_ff;
   logic                neg_a_ff, neg_b_ff;

   logic [SUM_BITS-1:0]          mag_a;
   logic [SUM_BITS-1:0]          mag_b;
   logic [SPAN_BITS-1:0]         mag_span;
   logic [DIV_BITS+SUM_BITS-1:0] step_a;
   logic [DIV_BITS+SUM_BITS-1:0] step_b;

   // one restoring step: returns {remainder, shifted dividend with quotient bit}
   function automatic logic [DIV_BITS+SUM_BITS-1:0] div_step(
      input logic [DIV_BITS-1:0] rem,
      input logic [SUM_BITS-1:0] dvd,
      input logic [DIV_BITS-1:0] dvsr
   );
      logic [DIV_BITS:0]   shifted;
      logic [DIV_BITS:0]   diff;
      logic [DIV_BITS-1:0] rem_n;
      logic                qbit;
      shifted = {rem, dvd[SUM_BITS-1]};
      diff    = shifted - {1'b0, dvsr};
      qbit    = (shifted >= {1'b0, dvsr});
      rem_n   = qbit ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
      return {rem_n, dvd[SUM_BITS-2:0], qbit};
   endfunction

   // signed level from quotient magnitude, clamped to the flux range
   function automatic flux_type sat_level(input logic [SUM_BITS-1:0] q, input logic neg);
      logic [SUM_BITS-1:0] fmax;
      fmax = {{(SUM_BITS-FLUX_BITS+1){1'b0}}, {(FLUX_BITS-1){1'b1}}};
      if (neg) begin
         if (q > fmax + 1'b1) begin
            return {1'b1, {(FLUX_BITS-1){1'b0}}};
         end
         return (~q[FLUX_BITS-1:0]) + 1'b1;
      end
      if (q > fmax) begin
         return {1'b0, {(FLUX_BITS-1){1'b1}}};
      end
      return q[FLUX_BITS-1:0];
   endfunction

   // operand magnitudes
   always_comb begin
      mag_a    = dividend_a[SUM_BITS-1] ? (~dividend_a + 1'b1) : dividend_a;
      mag_b    = dividend_b[SUM_BITS-1] ? (~dividend_b + 1'b1) : dividend_b;
      mag_span = span[SPAN_BITS-1] ? (~span + 1'b1) : span;
      step_a   = div_step(rem_a_ff, dvd_a_ff, dvsr_ff);
      step_b   = div_step(rem_b_ff, dvd_b_ff, dvsr_ff);
   end

   // iteration control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(SUM_BITS - 1);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_a_ff <= mag_a;
         dvd_b_ff <= mag_b;
         rem_a_ff <= '0;
         rem_b_ff <= '0;
         dvsr_ff  <= {mag_span, 2'b00};
         neg_a_ff <= dividend_a[SUM_BITS-1] ^ span[SPAN_BITS-1];
         neg_b_ff <= dividend_b[SUM_BITS-1] ^ span[SPAN_BITS-1];
      end else if (busy_ff) begin
         {rem_a_ff, dvd_a_ff} <= step_a;
         {rem_b_ff, dvd_b_ff} <= step_b;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign level_a     = sat_level(dvd_a_ff, neg_a_ff);
   assign level_b     = sat_level(dvd_b_ff, neg_b_ff);

endmodule

[src/swmf_back.sv]
// ----------------------------------------------------------------------------
// swmf_back: multiply-accumulate and result stage
// pops terms, forms saturated flux times width products, accumulates both sums
// and on a nonempty finish term hands them to the divider; holds the result
// ----------------------------------------------------------------------------
module swmf_back (
   input  logic                       clock,
   input  logic                       reset,
   input  swmf_pkg::queue_status_type q_status,
   input  swmf_pkg::term_type         q_data,
   output logic                       q_pop,
   output logic                       empty,
   input  logic                       pop,
   output swmf_pkg::flux_type         target_level,
   output swmf_pkg::flux_type         model_level,
   output logic                       empty_window
);
   import swmf_pkg::*;

   typedef struct packed {
      sum_type  prod_t;
      sum_type  prod_m;
      logic     acc;
      logic     finish;
      span_type span;
      logic     empty;
   } stage_type;

   stage_type      s1_ff, s1_in;
   logic           s1_valid_ff, s1_valid_in;
   sum_type        sum_t_ff, sum_t_in;
   sum_type        sum_m_ff, sum_m_in;
   flux_type       res_t_ff, res_t_in;
   flux_type       res_m_ff, res_m_in;
   logic           res_empty_ff, res_empty_in;
   logic           res_valid_ff, res_valid_in;

   logic           fin_block;
   logic           s1_consume;
   logic           fire;
   logic           div_start;
   sum_type        add_t;
   sum_type        add_m;
   div_status_type div_status;
   flux_type       div_level_t;
   flux_type       div_level_m;

   // flux times doubled width, clamped to the sum range
   function automatic sum_type sat_term(input flux_type f, input w2_type w);
      logic signed [PROD_BITS-1:0] p;
      logic signed [WIDE_BITS-1:0] pw;
      logic signed [WIDE_BITS-1:0] smax;
      logic signed [WIDE_BITS-1:0] smin;
      p    = f * w;
      pw   = WIDE_BITS'(p);
      smax = WIDE_BITS'($signed({1'b0, {(SUM_BITS-1){1'b1}}}));
      smin = WIDE_BITS'($signed({1'b1, {(SUM_BITS-1){1'b0}}}));
      if (pw > smax) begin
         return smax[SUM_BITS-1:0];
      end
      if (pw < smin) begin
         return smin[SUM_BITS-1:0];
      end
      return pw[SUM_BITS-1:0];
   endfunction

   // saturating accumulate
   function automatic sum_type sat_add(input sum_type a, input sum_type b);
      logic signed [SUM_BITS:0] s;
      s = a + b;
      if (s[SUM_BITS] != s[SUM_BITS-1]) begin
         return s[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
      end
      return s[SUM_BITS-1:0];
   endfunction

   // stage control: a finish term waits for divider and result register
   always_comb begin
      fin_block   = div_status.busy || div_status.done || res_valid_ff;
      s1_consume  = !(s1_valid_ff && s1_ff.finish && fin_block);
      q_pop       = q_status.nonempty && (!s1_valid_ff || s1_consume);
      fire        = s1_valid_ff && s1_consume;
      div_start   = fire && s1_ff.finish && !s1_ff.empty;
      s1_valid_in = q_pop ? 1'b1 : (s1_consume ? 1'b0 : s1_valid_ff);
   end

   // product stage
   always_comb begin
      s1_in        = s1_ff;
      if (q_pop) begin
         s1_in.prod_t = sat_term(q_data.target, q_data.w2);
         s1_in.prod_m = sat_term(q_data.model, q_data.w2);
         s1_in.acc    = q_data.acc;
         s1_in.finish = q_data.finish;
         s1_in.span   = q_data.span;
         s1_in.empty  = q_data.empty;
      end
   end

   // accumulate stage and result register
   always_comb begin
      add_t        = s1_ff.acc ? sat_add(sum_t_ff, s1_ff.prod_t) : sum_t_ff;
      add_m        = s1_ff.acc ? sat_add(sum_m_ff, s1_ff.prod_m) : sum_m_ff;
      sum_t_in     = sum_t_ff;
      sum_m_in     = sum_m_ff;
      res_t_in     = res_t_ff;
      res_m_in     = res_m_ff;
      res_empty_in = res_empty_ff;
      res_valid_in = res_valid_ff;
      if (fire) begin
         if (s1_ff.finish) begin
            sum_t_in = '0;
            sum_m_in = '0;
            if (s1_ff.empty) begin
               res_t_in     = '0;
               res_m_in     = '0;
               res_empty_in = 1'b1;
               res_valid_in = 1'b1;
            end
         end else begin
            sum_t_in = add_t;
            sum_m_in = add_m;
         end
      end
      if (div_status.done) begin
         res_t_in     = div_level_t;
         res_m_in     = div_level_m;
         res_empty_in = 1'b0;
         res_valid_in = 1'b1;
      end
      if (pop && res_valid_ff) begin
         res_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         sum_t_ff     <= '0;
         sum_m_ff     <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         sum_t_ff     <= sum_t_in;
         sum_m_ff     <= sum_m_in;
         res_valid_ff <= res_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_ff        <= s1_in;
      res_t_ff     <= res_t_in;
      res_m_ff     <= res_m_in;
      res_empty_ff <= res_empty_in;
   end

   swmf_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend_a (add_t),
      .dividend_b (add_m),
      .span       (s1_ff.span),
      .status     (div_status),
      .level_a    (div_level_t),
      .level_b    (div_level_m)
   );

   assign empty        = !res_valid_ff;
   assign target_level = res_t_ff;
   assign model_level  = res_m_ff;
   assign empty_window = res_empty_ff;

   // no pop from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_status.nonempty)
      else $error("term popped from empty queue");

   // divider only started when idle
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (!div_status.busy && !div_status.done))
      else $error("divider restarted while busy");

   // a divider result never lands on a waiting result
   a_res_free: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> !res_valid_ff)
      else $error("result register overwritten");

   // empty window finish gives a result next cycle
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (fire && s1_ff.finish && s1_ff.empty) |=> (res_valid_ff && res_empty_ff))
      else $error("empty window result missing");

endmodule

[src/spectrum_window_mean_flux.sv]
// ----------------------------------------------------------------------------
// spectrum_window_mean_flux: half mean flux of two spectra over a window
// throughput: one sample per cycle; a last sample holds full high until its
// finish term enters the queue, and a spectrum end waits in the back end while
// the divider runs or a result is unread, so the input stalls once the term
// queue fills behind it; a finish term passes the queue and the product stage,
// then the shared divider (one quotient bit per cycle); an empty window skips it
// reset: window edges return to 72000 and 136000, spectrum state and queue clear
// ----------------------------------------------------------------------------
module spectrum_window_mean_flux (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample channel
   input  logic                                  push,
   output logic                                  full,
   input  swmf_pkg::wave_type                    req_wavelength,
   input  swmf_pkg::flux_type                    req_target_flux,
   input  swmf_pkg::flux_type                    req_model_flux,
   input  logic                                  req_last_sample,
   // result channel
   output logic                                  empty,
   input  logic                                  pop,
   output swmf_pkg::flux_type                    rsp_target_level,
   output swmf_pkg::flux_type                    rsp_model_level,
   output logic                                  rsp_empty_window,
   // register port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [swmf_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [swmf_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [swmf_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                  pready
);
   import swmf_pkg::*;

   wave_type         window_start_ff, window_start_in;
   wave_type         window_end_ff, window_end_in;
   logic             csr_write;
   logic             csr_index;

   logic             q_push;
   logic             q_pop;
   term_type         q_wr_data;
   term_type         q_rd_data;
   queue_status_type q_status;

   // register write decode
   always_comb begin
      csr_write       = psel && penable && pwrite;
      csr_index       = paddr[2];
      window_start_in = window_start_ff;
      window_end_in   = window_end_ff;
      if (csr_write) begin
         case (csr_index)
            REG_WINDOW_START: window_start_in = pwdata[WAVE_BITS-1:0];
            REG_WINDOW_END:   window_end_in   = pwdata[WAVE_BITS-1:0];
            default: begin
               window_start_in = window_start_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_start_ff <= WINDOW_START_RESET;
         window_end_ff   <= WINDOW_END_RESET;
      end else begin
         window_start_ff <= window_start_in;
         window_end_ff   <= window_end_in;
      end
   end

   // register read
   always_comb begin
      case (csr_index)
         REG_WINDOW_START: prdata = CSR_DATA_BITS'(window_start_ff);
         REG_WINDOW_END:   prdata = CSR_DATA_BITS'(window_end_ff);
         default:          prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   swmf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .window_start (window_start_ff),
      .window_end   (window_end_ff),
      .push         (push),
      .full         (full),
      .wavelength   (req_wavelength),
      .target_flux  (req_target_flux),
      .model_flux   (req_model_flux),
      .last_sample  (req_last_sample),
      .q_status     (q_status),
      .q_push       (q_push),
      .q_data       (q_wr_data)
   );

   swmf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .status  (q_status)
   );

   swmf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_status     (q_status),
      .q_data       (q_rd_data),
      .q_pop        (q_pop),
      .empty        (empty),
      .pop          (pop),
      .target_level (rsp_target_level),
      .model_level  (rsp_model_level),
      .empty_window (rsp_empty_window)
   );

endmodule
